/* rtl/quic_header_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the QUIC header parser
// Shared implication checks, clocked on a rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUIC_HEADER_PARSER_ASSERT_SVH
`define QUIC_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication
`define QHP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define QHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qhp_pkg.sv */
// ----------------------------------------------------------------------------
// QHP package
// Types, codes and constants shared by the QUIC header parser modules.
// ----------------------------------------------------------------------------
package qhp_pkg;

    localparam logic [4:0] SHORT_ID_BYTES = 5'd8;
    localparam int         TDATA_W        = 128;

    localparam logic [1:0] KIND_DEST = 2'd0;
    localparam logic [1:0] KIND_SRC  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_VERSION = 8'b0000_0010,
        PH_LENS    = 8'b0000_0100,
        PH_DEST    = 8'b0000_1000,
        PH_SRC     = 8'b0001_0000,
        PH_VFIRST  = 8'b0010_0000,
        PH_VREST   = 8'b0100_0000,
        PH_PN      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id_byte;
        logic [4:0]  id_index;
        logic        header_done;
        logic        is_long;
        logic [6:0]  pkt_type;
        logic [31:0] pkt_num;
        logic [2:0]  pn_length;
        logic [61:0] pay_len;
        logic [4:0]  dest_id_length;
        logic [4:0]  src_id_length;
    } qhp_result_t;

    typedef struct packed {
        logic hdr_active;
        logic fire;
    } qhp_status_t;

    // Connection-ID length nibble: zero stays zero, else n + 3
    function automatic logic [4:0] id_len_decode(input logic [3:0] nib);
        logic [4:0] len;
        len = (nib == 4'd0) ? 5'd0 : ({1'b0, nib} + 5'd3);
        return len;
    endfunction

endpackage

/* rtl/qhp_in_stage.sv */
// ----------------------------------------------------------------------------
// QHP input stage
// Registers one incoming byte and its start flag ahead of the parser.
// ----------------------------------------------------------------------------
module qhp_in_stage
    import qhp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_byte,
    input  logic       s_sof,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_sof
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       sof_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_byte;
            sof_reg  <= s_sof;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_sof   = sof_reg;

endmodule

/* rtl/qhp_core.sv */
// ----------------------------------------------------------------------------
// QHP parser core
// Header state machine: advances one byte per fire and forms the result.
// ----------------------------------------------------------------------------
module qhp_core
    import qhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_sof,
    input  logic        out_ready,
    output logic        res_load,
    output qhp_result_t res,
    output qhp_status_t status
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [4:0]  bc_reg, bc_next;
    logic [4:0]  dest_len_reg, dest_len_next;
    logic [4:0]  src_len_reg, src_len_next;
    logic [61:0] vacc_reg, vacc_next;
    logic [3:0]  vbytes_reg, vbytes_next;
    logic [31:0] pn_reg, pn_next;
    logic [2:0]  pn_len_reg, pn_len_next;

    logic        fire;
    logic        emit;
    logic        done;
    logic [1:0]  kind;
    logic [7:0]  idb;
    logic [4:0]  idx;
    logic [4:0]  bc_inc;
    logic        lng;

    assign fire   = in_valid && out_ready;
    assign bc_inc = bc_reg + 5'd1;

    always_comb begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        bc_next       = bc_reg;
        dest_len_next = dest_len_reg;
        src_len_next  = src_len_reg;
        vacc_next     = vacc_reg;
        vbytes_next   = vbytes_reg;
        pn_next       = pn_reg;
        pn_len_next   = pn_len_reg;
        emit          = 1'b0;
        done          = 1'b0;
        kind          = KIND_NONE;
        idb           = 8'd0;
        idx           = 5'd0;

        if (in_sof) begin
            type_next    = in_byte;
            bc_next      = 5'd0;
            vacc_next    = '0;
            vbytes_next  = 4'd0;
            pn_next      = 32'd0;
            src_len_next = 5'd0;
            if (in_byte[7]) begin
                dest_len_next = 5'd0;
                pn_len_next   = 3'd4;
                phase_next    = PH_VERSION;
            end else begin
                dest_len_next = SHORT_ID_BYTES;
                case (in_byte[1:0])
                    2'd0:    pn_len_next = 3'd1;
                    2'd1:    pn_len_next = 3'd2;
                    2'd2:    pn_len_next = 3'd4;
                    default: pn_len_next = 3'd0;
                endcase
                phase_next = PH_DEST;
            end
        end else begin
            unique case (phase_reg)
                PH_VERSION: begin
                    bc_next = bc_inc;
                    if (bc_inc >= 5'd4) begin
                        bc_next    = 5'd0;
                        phase_next = PH_LENS;
                    end
                end
                PH_LENS: begin
                    dest_len_next = id_len_decode(in_byte[7:4]);
                    src_len_next  = id_len_decode(in_byte[3:0]);
                    bc_next       = 5'd0;
                    // only long headers reach here, so no IDs means varint next
                    if (dest_len_next != 5'd0) begin
                        phase_next = PH_DEST;
                    end else if (src_len_next != 5'd0) begin
                        phase_next = PH_SRC;
                    end else begin
                        phase_next = PH_VFIRST;
                    end
                end
                PH_DEST: begin
                    emit    = 1'b1;
                    kind    = KIND_DEST;
                    idb     = in_byte;
                    idx     = bc_reg;
                    bc_next = bc_inc;
                    if (bc_inc >= dest_len_reg) begin
                        bc_next = 5'd0;
                        if (type_reg[7] && src_len_reg != 5'd0) begin
                            phase_next = PH_SRC;
                        end else if (type_reg[7]) begin
                            phase_next = PH_VFIRST;
                        end else if (pn_len_reg == 3'd0) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_PN;
                        end
                    end
                end
                PH_SRC: begin
                    emit    = 1'b1;
                    kind    = KIND_SRC;
                    idb     = in_byte;
                    idx     = bc_reg;
                    bc_next = bc_inc;
                    if (bc_inc >= src_len_reg) begin
                        bc_next = 5'd0;
                        if (type_reg[7]) begin
                            phase_next = PH_VFIRST;
                        end else if (pn_len_reg == 3'd0) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_PN;
                        end
                    end
                end
                PH_VFIRST: begin
                    vacc_next = {56'd0, in_byte[5:0]};
                    case (in_byte[7:6])
                        2'd0:    vbytes_next = 4'd0;
                        2'd1:    vbytes_next = 4'd1;
                        2'd2:    vbytes_next = 4'd3;
                        default: vbytes_next = 4'd7;
                    endcase
                    phase_next = (vbytes_next == 4'd0) ? PH_PN : PH_VREST;
                    bc_next    = 5'd0;
                end
                PH_VREST: begin
                    vacc_next   = {vacc_reg[53:0], in_byte};
                    vbytes_next = vbytes_reg - 4'd1;
                    if (vbytes_next == 4'd0) begin
                        phase_next = PH_PN;
                        bc_next    = 5'd0;
                    end
                end
                PH_PN: begin
                    pn_next = {pn_reg[23:0], in_byte};
                    bc_next = bc_inc;
                    if (bc_inc >= {2'd0, pn_len_reg}) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        bc_next    = 5'd0;
                    end
                end
                default: begin
                    // idle bytes carry nothing; stray codes fall back to idle
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign lng = type_next[7];

    always_comb begin
        res                = '0;
        res.kind           = kind;
        res.id_byte        = idb;
        res.id_index       = idx;
        if (done) begin
            res.header_done    = 1'b1;
            res.is_long        = lng;
            res.pkt_type       = lng ? type_next[6:0] : 7'd0;
            res.pkt_num        = pn_next;
            res.pn_length      = pn_len_next;
            res.pay_len        = lng ? vacc_next : 62'd0;
            res.dest_id_length = dest_len_next;
            res.src_id_length  = lng ? src_len_next : 5'd0;
        end
    end

    assign res_load          = fire && (emit || done);
    assign status.hdr_active = (phase_reg != PH_IDLE);
    assign status.fire       = fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            type_reg     <= 8'd0;
            bc_reg       <= 5'd0;
            dest_len_reg <= 5'd0;
            src_len_reg  <= 5'd0;
            vacc_reg     <= '0;
            vbytes_reg   <= 4'd0;
            pn_reg       <= 32'd0;
            pn_len_reg   <= 3'd0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            bc_reg       <= bc_next;
            dest_len_reg <= dest_len_next;
            src_len_reg  <= src_len_next;
            vacc_reg     <= vacc_next;
            vbytes_reg   <= vbytes_next;
            pn_reg       <= pn_next;
            pn_len_reg   <= pn_len_next;
        end
    end

endmodule

/* rtl/qhp_out_stage.sv */
// ----------------------------------------------------------------------------
// QHP output stage
// Result register: holds one item until the sink takes it and packs it.
// ----------------------------------------------------------------------------
module qhp_out_stage
    import qhp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_load,
    input  qhp_result_t        res,
    output logic               out_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic        valid_reg;
    logic        valid_next;
    qhp_result_t res_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = res_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load && out_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.header_done;
    assign m_tdata  = {res_reg.src_id_length, res_reg.dest_id_length,
                       res_reg.pay_len, res_reg.pn_length,
                       res_reg.pkt_num, res_reg.pkt_type,
                       res_reg.is_long, res_reg.id_index, res_reg.id_byte};

endmodule

/* rtl/quic_header_parser.sv */
// Path: input register, combinational core, output register; the result item
// of a byte shows on the m_ side (bytes that make no result give none).
// Throughput: one byte per cycle with no stalls; m_tready low holds the result
// register, and s_tready drops once a byte also waits in the input register.
// Reset: synchronous aresetn clears both valid flags and returns the parser
// to idle with all header state zeroed.
// ----------------------------------------------------------------------------
// QUIC header parser
// Byte-serial parser of early-draft QUIC headers; emits ID bytes and summary.
// ----------------------------------------------------------------------------
`include "quic_header_parser_assert.svh"

module quic_header_parser
    import qhp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tuser,   // start_of_header
    output logic               m_tvalid,
    input  logic               m_tready,
    // id_byte, id_index, is_long, pkt_type, pkt_num, pn_length,
    // pay_len, dest_id_length, src_id_length
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // header_done
);

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_sof;
    logic        out_ready;
    logic        res_load;
    qhp_result_t res;
    qhp_status_t status;

    qhp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_sof    (s_tuser),
        .take     (out_ready),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_sof   (in_sof)
    );

    qhp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_sof    (in_sof),
        .out_ready (out_ready),
        .res_load  (res_load),
        .res       (res),
        .status    (status)
    );

    qhp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `QHP_ASSERT_IMPLIES(a_none_is_done, aclk, aresetn, m_tvalid && m_tuser == KIND_NONE, m_tlast, "item without ID byte is not a header completion")

    `QHP_ASSERT_IMPLIES(a_kind_legal, aclk, aresetn, m_tvalid, m_tuser != 2'd3, "illegal kind on result")

    `QHP_ASSERT_IMPLIES(a_short_no_payload, aclk, aresetn, m_tvalid && m_tlast && !m_tdata[13], m_tdata[117:56] == 62'd0 && m_tdata[127:123] == 5'd0, "short header reports long-only fields")

    `QHP_ASSERT_NEXT(a_done_to_idle, aclk, aresetn, res_load && res.header_done && status.fire, !status.hdr_active, "parser not idle after header completion")

endmodule
